@@ hdl/msa_pkg.sv @@
// msa_pkg: shared widths, command and status codes, register map for the
// multi-stack shared-array block. No dependencies.
package msa_pkg;

  localparam int TOTAL_W   = 7;    // total_size register and region pointers
  localparam int NSTK_W    = 4;    // num_stacks register
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 4;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam int MEM_DEPTH_DEF  = 64;
  localparam int MAX_STACKS_DEF = 8;

  localparam logic [TOTAL_W-1:0] TOTAL_RST = 7'd64;
  localparam logic [NSTK_W-1:0]  NSTK_RST  = 4'd1;

  // register index as seen at paddr[2]
  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_NSTK  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_SHOW = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_BAD   = 2'd3
  } status_t;

endpackage

@@ hdl/msa_in_if.sv @@
// msa_in_if: command channel (valid/ready plus cmd, stack index, value).
// Depends on msa_pkg for field widths.
interface msa_in_if;
  logic                              valid;
  logic                              ready;
  logic [msa_pkg::CMD_W-1:0]         cmd;
  logic [msa_pkg::IDX_W-1:0]         stack_index;
  logic signed [msa_pkg::DATA_W-1:0] value;

  modport source (output valid, cmd, stack_index, value, input ready);
  modport sink   (input valid, cmd, stack_index, value, output ready);
endinterface

@@ hdl/msa_out_if.sv @@
// msa_out_if: result channel (valid/ready plus data, status, last).
// Depends on msa_pkg for field widths.
interface msa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [msa_pkg::DATA_W-1:0] data;
  logic [msa_pkg::STATUS_W-1:0]      status;
  logic                              last;

  modport source (output valid, data, status, last, input ready);
  modport sink   (input valid, data, status, last, output ready);
endinterface

@@ hdl/msa_div.sv @@
// msa_div: restoring divider, one quotient bit per cycle, for region size.
// Depends on msa_pkg. Starts itself out of reset and on start.
module msa_div #(
  parameter int NW = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [msa_pkg::TOTAL_W-1:0] dividend,
  input  logic [NW-1:0]               divisor,
  output logic                        busy,
  output logic [msa_pkg::TOTAL_W-1:0] quotient
);
  localparam int TW  = msa_pkg::TOTAL_W;
  localparam int SCW = $clog2(TW);

  logic            busy_r;
  logic [SCW-1:0]  step_r;
  logic [NW-1:0]   rem_r;
  logic [TW-1:0]   quo_r;
  logic [NW-1:0]   rem_src;
  logic [TW-1:0]   quo_src;
  logic [NW:0]     part;
  logic [NW:0]     diff;
  logic            ge;
  logic [NW-1:0]   rem_nxt;
  logic [TW-1:0]   quo_nxt;

  // first step takes the dividend straight from the input and a zero remainder
  always_comb begin
    rem_src = (step_r == '0) ? '0 : rem_r;
    quo_src = (step_r == '0) ? dividend : quo_r;
    part    = {rem_src, quo_src[TW-1]};
    ge      = part >= {1'b0, divisor};
    diff    = part - {1'b0, divisor};
    rem_nxt = ge ? diff[NW-1:0] : part[NW-1:0];
    quo_nxt = {quo_src[TW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == SCW'(TW - 1)) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + SCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !start) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

@@ hdl/multi_stack_shared_array.sv @@
// Several stacks in one shared word memory. Push/bad-index/empty: the beat is
// captured, the result is registered from the execute state, then idle again.
// Pop: one synchronous memory read in the execute state, result registered in stream.
// Display: first element as for pop, then one element per cycle from the
// memory read port while out_bus.ready holds; next beat once the last is registered.
// Reset (rst_n, sync, active low) and every config write empty all stacks and
// run the region divider; input is held off meanwhile. Memory not cleared.
module multi_stack_shared_array #(
  parameter int MEM_DEPTH  = msa_pkg::MEM_DEPTH_DEF,
  parameter int MAX_STACKS = msa_pkg::MAX_STACKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  msa_in_if.sink                      in_bus,
  msa_out_if.source                   out_bus,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [msa_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [msa_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [msa_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  localparam int PW  = msa_pkg::TOTAL_W;                  // pointer / count width
  localparam int AW  = $clog2(MEM_DEPTH);                 // memory address
  localparam int SW  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int NW  = $clog2(MAX_STACKS + 1);            // effective stack count
  localparam int IXW = (NW > msa_pkg::IDX_W) ? NW : msa_pkg::IDX_W;
  localparam int DW  = msa_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_STREAM = 3'b100
  } state_t;

  // ---------------------------------------------------------------------
  // Config registers (APB, zero wait states)
  // ---------------------------------------------------------------------
  logic [PW-1:0]               total_r;
  logic [msa_pkg::NSTK_W-1:0]  nstk_r;
  logic                        cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= msa_pkg::TOTAL_RST;
      nstk_r  <= msa_pkg::NSTK_RST;
    end else if (cfg_we) begin
      if (cfg_paddr[2] == msa_pkg::REG_NSTK) begin
        nstk_r <= cfg_pwdata[msa_pkg::NSTK_W-1:0];
      end else begin
        total_r <= cfg_pwdata[PW-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == msa_pkg::REG_NSTK) ?
                      msa_pkg::APB_DW'(nstk_r) : msa_pkg::APB_DW'(total_r);

  // Registers keep the raw bits; clamp here.
  logic [PW-1:0]  t_eff;
  logic [IXW-1:0] n_wide;
  logic [NW-1:0]  n_eff;

  always_comb begin
    if (total_r == '0) begin
      t_eff = PW'(1);
    end else if (total_r > PW'(MEM_DEPTH)) begin
      t_eff = PW'(MEM_DEPTH);
    end else begin
      t_eff = total_r;
    end
    n_wide = IXW'(nstk_r);
    if (n_wide == '0) begin
      n_eff = NW'(1);
    end else if (n_wide > IXW'(MAX_STACKS)) begin
      n_eff = NW'(MAX_STACKS);
    end else begin
      n_eff = n_wide[NW-1:0];
    end
  end

  // Region size = t_eff / n_eff, recomputed after reset and config writes.
  logic          div_busy;
  logic [PW-1:0] size;

  msa_div #(.NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_we),
    .dividend (t_eff),
    .divisor  (n_eff),
    .busy     (div_busy),
    .quotient (size)
  );

  // ---------------------------------------------------------------------
  // Input capture. Stack i starts at word size*i; only its fill count is
  // kept, so emptying every stack is a single clear of the fill counts.
  // ---------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic            in_ready;
  logic            in_take;

  msa_pkg::cmd_t   cmd_r;
  logic [SW-1:0]   s_r;
  logic [DW-1:0]   value_r;
  logic            bad_r;
  logic            more_r;     // a higher stack bounds this one
  logic [PW-1:0]   start_r;
  logic [PW-1:0]   cnt_sel_r;
  logic [PW-1:0]   cnt_r [MAX_STACKS];

  logic [IXW-1:0]  in_idx;

  assign in_ready     = (state_r == ST_IDLE) && !div_busy;
  assign in_bus.ready = in_ready;
  assign in_take      = in_bus.valid && in_ready;
  assign in_idx       = IXW'(in_bus.stack_index);

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r     <= msa_pkg::cmd_t'(in_bus.cmd);
      s_r       <= in_bus.stack_index[SW-1:0];
      value_r   <= in_bus.value;
      bad_r     <= in_idx >= IXW'(n_eff);
      more_r    <= (in_idx + IXW'(1)) < IXW'(n_eff);
      start_r   <= PW'(size * in_bus.stack_index);
      cnt_sel_r <= cnt_r[in_bus.stack_index[SW-1:0]];
    end
  end

  // ---------------------------------------------------------------------
  // Execute / stream control
  // ---------------------------------------------------------------------
  logic                    slot_free;
  logic                    out_valid_r;
  logic                    emit;
  logic [DW-1:0]           emit_data;
  msa_pkg::status_t        emit_status;
  logic                    emit_last;

  logic [PW-1:0]           sum;       // start + count: next free word
  logic                    full;
  logic                    mem_we;
  logic                    mem_re;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;
  logic [DW-1:0]           rdata_r;
  logic [AW-1:0]           rd_addr_r, rd_addr_nxt;
  logic [PW-1:0]           rem_r, rem_nxt;
  logic                    cnt_we;
  logic [PW-1:0]           cnt_wdata;

  assign slot_free = !out_valid_r || out_bus.ready;
  assign sum       = start_r + cnt_sel_r;
  assign full      = (more_r && (cnt_sel_r == size)) || (sum == t_eff);
  assign mem_waddr = sum[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    emit        = 1'b0;
    emit_data   = '0;
    emit_status = msa_pkg::STS_OK;
    emit_last   = 1'b1;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = rd_addr_r;
    rd_addr_nxt = rd_addr_r;
    rem_nxt     = rem_r;
    cnt_we      = 1'b0;
    cnt_wdata   = cnt_sel_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        priority if (cmd_r == msa_pkg::CMD_NONE) begin
          state_nxt = ST_IDLE;
        end else if (bad_r) begin
          if (slot_free) begin
            emit        = 1'b1;
            emit_status = msa_pkg::STS_BAD;
            state_nxt   = ST_IDLE;
          end
        end else if (cmd_r == msa_pkg::CMD_PUSH) begin
          if (slot_free) begin
            emit        = 1'b1;
            emit_status = full ? msa_pkg::STS_FULL : msa_pkg::STS_OK;
            mem_we      = !full;
            cnt_we      = !full;
            cnt_wdata   = cnt_sel_r + PW'(1);
            state_nxt   = ST_IDLE;
          end
        end else if (cnt_sel_r == '0) begin
          if (slot_free) begin
            emit        = 1'b1;
            emit_status = msa_pkg::STS_EMPTY;
            state_nxt   = ST_IDLE;
          end
        end else begin
          // pop is a one-element stream that also drops the count
          mem_re      = 1'b1;
          mem_raddr   = AW'(sum - PW'(1));
          rd_addr_nxt = AW'(sum - PW'(2));
          rem_nxt     = (cmd_r == msa_pkg::CMD_POP) ? PW'(1) : cnt_sel_r;
          cnt_we      = (cmd_r == msa_pkg::CMD_POP);
          cnt_wdata   = cnt_sel_r - PW'(1);
          state_nxt   = ST_STREAM;
        end
      end

      ST_STREAM: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_data = rdata_r;
          emit_last = (rem_r == PW'(1));
          if (rem_r == PW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            // fetch the next element below while this one goes out
            mem_re      = 1'b1;
            mem_raddr   = rd_addr_r;
            rd_addr_nxt = rd_addr_r - AW'(1);
            rem_nxt     = rem_r - PW'(1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    rem_r     <= rem_nxt;
  end

  // Fill counts: reset and config writes empty every stack at once.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int k = 0; k < MAX_STACKS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (cnt_we) begin
      cnt_r[s_r] <= cnt_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Shared word memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [DW-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= value_r;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [DW-1:0]            out_data_r;
  msa_pkg::status_t         out_status_r;
  logic                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r   <= emit_data;
      out_status_r <= emit_status;
      out_last_r   <= emit_last;
    end
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.data   = out_data_r;
  assign out_bus.status = out_status_r;
  assign out_bus.last   = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cfg_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> div_busy)
    else $error("region divider did not start after config write");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("result written over a pending beat");

  a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (PW'(mem_waddr) < t_eff))
    else $error("push beyond shared memory size");

  a_stream_region: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM && mem_re) |-> (PW'(mem_raddr) >= start_r))
    else $error("display read below stack region");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> (cnt_wdata <= t_eff))
    else $error("stack fill count exceeds memory size");

endmodule
